@@ rtl/core/rlat_pkg.sv @@
// ----------------------------------------------------------------------------
// rlat_pkg: shared types and codes for the run-length attribute table
// Opcode constants and a memory edit command type.
// ----------------------------------------------------------------------------
package rlat_pkg;

	localparam logic [2:0] OP_SET   = 3'd0;
	localparam logic [2:0] OP_ERASE = 3'd1;
	localparam logic [2:0] OP_SHUP  = 3'd2;
	localparam logic [2:0] OP_SHDN  = 3'd3;
	localparam logic [2:0] OP_GET   = 3'd4;
	localparam logic [2:0] OP_RANGE = 3'd5;

	// memory edit command encoding (the sequencer drives the memory port directly)
	typedef enum logic [2:0] {
		MOV_NONE  = 3'd0,
		MOV_COPY  = 3'd1,  // entry[dst] <= entry[src]
		MOV_WRITE = 3'd2,  // entry[dst] <= {end,attr}
		MOV_ADD   = 3'd3,  // entry[dst].end += delta
		MOV_END   = 3'd4   // entry[dst].end <= end
	} mov_t;

endpackage

@@ rtl/core/run_length_attribute_table.sv @@
// ----------------------------------------------------------------------------
// run_length_attribute_table: sorted run table with edit and lookup requests
// Sequencer walks the run memory one entry per step using one shared
// compare/add unit.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_stall) takes one request: opcode,
//   position, attr_id, range_length. The output channel (out_valid/out_stall)
//   returns one result per request.
//   A request walks the table one entry at a time through a single memory
//   read port: it visits runs in order to locate the run, reads both
//   neighbours, moves runs for an insert or remove and adjusts run ends
//   for a shift. An unused opcode goes straight to the result. The worst
//   case is an erase that joins its neighbours near the front of the
//   table. The cost is set by the single memory port and the shared
//   compare/add unit.
//   in_stall is high from acceptance until the result has been written into
//   the output register; the next request may be taken while that result
//   still waits for the receiver. A stalled result holds its value; a
//   second result waits in the sequencer until the register frees.
//   Reset clears the run count and the sequencer; the memory is not
//   cleared, since only entries below the run count are ever read.
// ----------------------------------------------------------------------------
module run_length_attribute_table #(
	parameter int MAX_RUNS  = 64,
	parameter int POS_BITS  = 16,
	parameter int ATTR_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           opcode,
	input  logic [POS_BITS-1:0]  position,
	input  logic [ATTR_BITS-1:0] attr_id,
	input  logic [15:0]          range_length,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ATTR_BITS-1:0] attr_out,
	output logic                 hit,
	output logic                 range_uniform,
	output logic                 table_full,
	output logic [$clog2(MAX_RUNS+1)-1:0] run_count_out
);
	import rlat_pkg::*;

	localparam int IB = $clog2(MAX_RUNS);
	localparam int CB = $clog2(MAX_RUNS+1);
	localparam int SB = ((POS_BITS > 16) ? POS_BITS : 16) + 1;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_LRD   = 16'h0002,  // read entry k
		S_LCMP  = 16'h0004,  // compare entry k
		S_PLAN  = 16'h0008,  // read neighbours and decide
		S_RDA   = 16'h0010,  // generic read issue
		S_RDB   = 16'h0020,  // generic read land
		S_SHR   = 16'h0040,  // shift entries right
		S_SHRW  = 16'h0080,
		S_SHL   = 16'h0100,  // shift entries left
		S_SHLW  = 16'h0200,
		S_ADD   = 16'h0400,  // add delta from start
		S_ADDW  = 16'h0800,
		S_DONE  = 16'h1000,
		S_SETD  = 16'h2000,  // set decision
		S_ERD   = 16'h4000,  // erase decision
		S_STEP  = 16'h8000   // execute next micro step of a set
	} state_t;

	state_t state_q;

	logic [2:0]           op_q;
	logic [POS_BITS-1:0]  pos_q;
	logic [ATTR_BITS-1:0] attr_q;
	logic [15:0]          len_q;
	logic [CB-1:0]        cnt_q;
	logic [CB-1:0]        k_q;      // located index
	logic [CB-1:0]        j_q;      // sweep index
	logic [CB-1:0]        stop_q;   // sweep end
	logic [POS_BITS-1:0]  delta_q;
	logic [POS_BITS-1:0]  ek_q, ekm_q;
	logic [ATTR_BITS-1:0] ak_q, akm_q, akp_q;
	logic                 hk_q, hkm_q, hkp_q; // valid neighbour captured
	logic [2:0]           plan_q;  // neighbour read phase
	logic [3:0]           step_q;  // set micro program
	logic [2:0]           act_q;   // selected set action
	logic                 full_r_q, hit_r_q, uni_r_q;
	logic [ATTR_BITS-1:0] ao_r_q;

	// memory port
	logic                 we;
	logic [IB-1:0]        waddr, raddr;
	logic [POS_BITS-1:0]  wend, rend;
	logic [ATTR_BITS-1:0] wattr, rattr;

	rlat_mem #(.MAX_RUNS(MAX_RUNS), .POS_BITS(POS_BITS), .ATTR_BITS(ATTR_BITS),
		.IDX_BITS(IB)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wend(wend), .wattr(wattr),
		.raddr(raddr), .rend(rend), .rattr(rattr));

	// set actions
	localparam logic [2:0] A_NONE   = 3'd0;
	localparam logic [2:0] A_SPLIT  = 3'd1; // insert two at k
	localparam logic [2:0] A_RMK2   = 3'd2; // remove k, maybe k-1
	localparam logic [2:0] A_EXTRM  = 3'd3; // end[k-1]=p, remove k
	localparam logic [2:0] A_ATTR   = 3'd4; // attr[k]=a
	localparam logic [2:0] A_EXTP   = 3'd5; // end[k-1]=p
	localparam logic [2:0] A_INSK   = 3'd6; // insert (p,a) at k
	localparam logic [2:0] A_TAIL   = 3'd7; // end[k]=p-1, maybe insert at k+1

	// shared unit: one add and one compare
	logic [POS_BITS-1:0] sum_a, sum_b, sum_y;
	assign sum_y = sum_a + sum_b;

	logic accept_in;
	assign accept_in = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);

	logic found;
	assign found = (k_q < cnt_q);

	logic [1:0] ins_n_q;  // entries being inserted
	logic       rm_again_q;

	// micro program for set writes after the shift
	function automatic logic [IB-1:0] ek_write_idx();
		logic [CB-1:0] i;
		i = k_q;
		case (step_q)
			4'd1: i = k_q;                // first inserted / k
			4'd2: i = CB'(k_q + 1'b1);    // second inserted
			4'd3: i = CB'(k_q - 1'b1);    // previous run
			default: i = k_q;
		endcase
		return i[IB-1:0];
	endfunction

	function automatic logic [POS_BITS+ATTR_BITS-1:0] step_data();
		logic [POS_BITS-1:0] e;
		logic [ATTR_BITS-1:0] a;
		e = pos_q; a = attr_q;
		case (act_q)
			A_SPLIT: if (step_q == 4'd1) begin
				e = pos_q - 1'b1; a = ak_q;
			end
			A_EXTRM, A_EXTP: begin
				e = pos_q; a = akm_q;
			end
			A_ATTR: begin
				e = ek_q; a = attr_q;
			end
			A_TAIL: if (step_q == 4'd1) begin
				e = pos_q - 1'b1; a = ak_q;
			end
			default: ;
		endcase
		return {e, a};
	endfunction

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wend  = rend;
		wattr = rattr;
		raddr = j_q[IB-1:0];
		sum_a = rend;
		sum_b = delta_q;
		case (state_q)
			S_LRD:  raddr = k_q[IB-1:0];
			// copy from as many entries below as are being inserted
			S_SHR:  raddr = IB'(j_q - CB'(ins_n_q));
			S_SHRW: begin
				we = 1'b1; waddr = j_q[IB-1:0];
			end
			S_SHL:  raddr = IB'(j_q + 1'b1);
			S_SHLW: begin
				we = 1'b1; waddr = j_q[IB-1:0];
			end
			S_ADD:  raddr = j_q[IB-1:0];
			S_ADDW: begin
				we = 1'b1; waddr = j_q[IB-1:0]; wend = sum_y;
			end
			S_STEP: begin
				we = 1'b1;
				waddr = ek_write_idx();
				{wend, wattr} = step_data();
			end
			default: ;
		endcase
	end

	// comparisons
	logic ge_p;
	assign ge_p = (rend >= pos_q);
	logic [SB-1:0] span_end;
	assign span_end = SB'(pos_q) + SB'(len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			out_valid  <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != S_DONE) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (accept_in) begin
					op_q <= opcode; pos_q <= position; attr_q <= attr_id;
					len_q <= range_length;
					k_q <= '0;
					full_r_q <= 1'b0; hit_r_q <= 1'b0; uni_r_q <= 1'b0;
					ao_r_q <= '0;
					if (opcode > OP_RANGE) state_q <= S_DONE;
					else state_q <= S_LRD;
				end
				S_LRD: begin
					if (k_q >= cnt_q) state_q <= S_PLAN;
					else state_q <= S_LCMP;
					plan_q <= 3'd0;
				end
				S_LCMP: begin
					if (ge_p) begin
						ek_q <= rend; ak_q <= rattr;
						state_q <= S_PLAN;
					end else begin
						k_q <= CB'(k_q + 1'b1);
						state_q <= S_LRD;
					end
				end
				S_PLAN: begin
					// read k-1 then k+1
					case (plan_q)
						3'd0: begin
							hkm_q <= 1'b0; hkp_q <= 1'b0;
							j_q <= CB'(k_q - 1'b1);
							plan_q <= (k_q != '0) ? 3'd1 : 3'd3;
						end
						3'd1: plan_q <= 3'd2;
						3'd2: begin
							ekm_q <= rend; akm_q <= rattr; hkm_q <= 1'b1;
							plan_q <= 3'd3;
						end
						3'd3: begin
							j_q <= CB'(k_q + 1'b1);
							plan_q <= (CB'(k_q + 1'b1) < cnt_q) ? 3'd4 : 3'd6;
						end
						3'd4: plan_q <= 3'd5;
						3'd5: begin
							akp_q <= rattr; hkp_q <= 1'b1; plan_q <= 3'd6;
						end
						default: begin
							case (op_q)
								OP_SET:   state_q <= S_SETD;
								OP_ERASE: state_q <= S_ERD;
								OP_SHUP: begin
									delta_q <= POS_BITS'(1); j_q <= k_q;
									state_q <= S_ADD;
								end
								OP_SHDN: begin
									delta_q <= '1; j_q <= k_q;
									state_q <= S_ADD;
								end
								OP_GET: begin
									if (found && ek_q == pos_q) begin
										hit_r_q <= 1'b1; ao_r_q <= ak_q;
									end
									state_q <= S_DONE;
								end
								default: begin
									uni_r_q <= !(found &&
										(span_end > SB'(ek_q) + SB'(1)));
									state_q <= S_DONE;
								end
							endcase
						end
					endcase
				end
				S_SETD: begin
					if (found && ak_q == attr_q) state_q <= S_DONE;
					else begin
						logic b, e2;
						b  = (pos_q == '0) || !found ||
							(hkm_q && ekm_q == pos_q - 1'b1);
						e2 = found && ek_q == pos_q;
						if (!b && !e2) begin
							if (CB'(cnt_q + 2'd2) > CB'(MAX_RUNS) ||
								32'(cnt_q) + 2 > MAX_RUNS) begin
								full_r_q <= 1'b1; state_q <= S_DONE;
							end else begin
								act_q <= A_SPLIT; ins_n_q <= 2'd2;
								j_q <= CB'(cnt_q + 1'b1); stop_q <= CB'(k_q + 2'd2);
								state_q <= S_SHR;
							end
						end else if (b && e2) begin
							if (hkp_q && akp_q == attr_q) begin
								act_q <= A_RMK2;
								rm_again_q <= hkm_q && akm_q == attr_q;
								j_q <= k_q; state_q <= S_SHL;
							end else if (hkm_q && akm_q == attr_q) begin
								act_q <= A_EXTRM; step_q <= 4'd3;
								rm_again_q <= 1'b0;
								state_q <= S_STEP;
							end else begin
								act_q <= A_ATTR; step_q <= 4'd1; state_q <= S_STEP;
							end
						end else if (b) begin
							if (hkm_q && akm_q == attr_q) begin
								act_q <= A_EXTP; step_q <= 4'd3; state_q <= S_STEP;
							end else if (32'(cnt_q) + 1 > MAX_RUNS) begin
								full_r_q <= 1'b1; state_q <= S_DONE;
							end else begin
								act_q <= A_INSK; ins_n_q <= 2'd1;
								j_q <= cnt_q; stop_q <= CB'(k_q + 1'b1);
								state_q <= S_SHR;
							end
						end else begin
							if (!(hkp_q && akp_q == attr_q) &&
								32'(cnt_q) + 1 > MAX_RUNS) begin
								full_r_q <= 1'b1; state_q <= S_DONE;
							end else begin
								act_q <= A_TAIL;
								ins_n_q <= (hkp_q && akp_q == attr_q) ? 2'd0 : 2'd1;
								j_q <= cnt_q; stop_q <= CB'(k_q + 2'd2);
								state_q <= (hkp_q && akp_q == attr_q) ? S_STEP : S_SHR;
								step_q <= 4'd1;
							end
						end
					end
				end
				S_SHR: begin
					if (j_q < stop_q || j_q == '0) begin
						step_q <= 4'd1;
						state_q <= S_STEP;
					end else state_q <= S_SHRW;
				end
				S_SHRW: begin
					j_q <= CB'(j_q - 1'b1);
					state_q <= S_SHR;
				end
				S_STEP: begin
					case (act_q)
						A_SPLIT: if (step_q == 4'd1) step_q <= 4'd2;
							else begin
								cnt_q <= CB'(cnt_q + 2'd2); state_q <= S_DONE;
							end
						A_INSK: begin
							cnt_q <= CB'(cnt_q + 1'b1); state_q <= S_DONE;
						end
						A_TAIL: if (step_q == 4'd1 && ins_n_q != 2'd0) step_q <= 4'd2;
							else begin
								cnt_q <= CB'(cnt_q + ins_n_q); state_q <= S_DONE;
							end
						A_EXTRM: begin
							j_q <= k_q; state_q <= S_SHL;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_SHL: begin
					if (CB'(j_q + 1'b1) >= cnt_q) begin
						cnt_q <= CB'(cnt_q - 1'b1);
						if (rm_again_q) begin
							rm_again_q <= 1'b0;
							k_q <= CB'(k_q - 1'b1); j_q <= CB'(k_q - 1'b1);
						end else if (op_q == OP_ERASE) begin
							state_q <= S_ERD; plan_q <= 3'd7;
						end else state_q <= S_DONE;
					end else state_q <= S_SHLW;
				end
				S_SHLW: begin
					j_q <= CB'(j_q + 1'b1);
					state_q <= S_SHL;
				end
				S_ERD: begin
					delta_q <= '1;
					if (plan_q != 3'd7) begin
						if (found && ek_q == pos_q &&
							(pos_q == '0 || (hkm_q && ekm_q == pos_q - 1'b1))) begin
							// remove k; merge k-1 with old k+1 if equal
							rm_again_q <= hkm_q && hkp_q && akm_q == akp_q;
							j_q <= k_q; state_q <= S_SHL;
						end else begin
							j_q <= k_q; state_q <= S_ADD;
						end
					end else begin
						// after removal: last run removed means no shift
						if (k_q >= cnt_q) state_q <= S_DONE;
						else begin
							j_q <= k_q; state_q <= S_ADD;
						end
					end
				end
				S_ADD: begin
					if (j_q >= cnt_q) state_q <= S_DONE;
					else state_q <= S_RDA;
				end
				S_RDA: state_q <= S_ADDW;
				S_ADDW: begin
					j_q <= CB'(j_q + 1'b1);
					state_q <= S_ADD;
				end
				S_DONE: if (!out_valid || !out_stall) begin
					out_valid <= 1'b1;
					attr_out <= ao_r_q; hit <= hit_r_q;
					range_uniform <= uni_r_q; table_full <= full_r_q;
					run_count_out <= cnt_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/rlat_mem.sv @@
// ----------------------------------------------------------------------------
// rlat_mem: run table storage
// One write port, one registered read port for run ends and attributes.
// ----------------------------------------------------------------------------
module rlat_mem #(
	parameter int MAX_RUNS  = 64,
	parameter int POS_BITS  = 16,
	parameter int ATTR_BITS = 8,
	parameter int IDX_BITS  = 6
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [IDX_BITS-1:0]  waddr,
	input  logic [POS_BITS-1:0]  wend,
	input  logic [ATTR_BITS-1:0] wattr,
	input  logic [IDX_BITS-1:0]  raddr,
	output logic [POS_BITS-1:0]  rend,
	output logic [ATTR_BITS-1:0] rattr
);
	logic [POS_BITS-1:0]  end_mem  [MAX_RUNS];
	logic [ATTR_BITS-1:0] attr_mem [MAX_RUNS];

	always_ff @(posedge clk) begin
		if (we) begin
			end_mem[waddr]  <= wend;
			attr_mem[waddr] <= wattr;
		end
		rend  <= end_mem[raddr];
		rattr <= attr_mem[raddr];
	end
endmodule
